@@ rtl/acpu_pkg.sv @@
package acpu_pkg;

  typedef struct packed {
    logic [7:0] command;
    logic [7:0] operand_byte;
    logic [7:0] port_in;
  } acpu_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  port_id;
    logic [7:0]  port_value;
    logic        strobe_level;
    logic [11:0] next_pc;
    logic [7:0]  acc_out;
    logic [7:0]  status_out;
    logic        flag_one;
    logic [1:0]  bytes_used;
    logic [1:0]  cycle_count;
    logic        unknown_opcode;
    logic        last;
  } acpu_out_t;

  localparam logic [1:0] KIND_RETIRE = 2'd0;
  localparam logic [1:0] KIND_PORT   = 2'd1;
  localparam logic [1:0] KIND_STROBE = 2'd2;

  localparam logic [1:0] PORT_BUS = 2'd0;
  localparam logic [1:0] PORT_P1  = 2'd1;
  localparam logic [1:0] PORT_P2  = 2'd2;

  localparam logic [7:0] ST_CY = 8'h80;
  localparam logic [7:0] ST_AC = 8'h40;
  localparam logic [7:0] ST_F0 = 8'h20;
  localparam logic [7:0] ST_BS = 8'h10;
  localparam logic [7:0] STATUS_RESET = 8'h08;

  typedef enum logic [1:0] {
    FMT_R,
    FMT_I,
    FMT_X,
    FMT_O
  } acpu_fmt_t;

  typedef struct packed {
    acpu_fmt_t  fmt;
    logic [7:0] op;
    logic [7:0] imm;
    logic [7:0] pin;
  } acpu_cmd_t;

endpackage

@@ rtl/acpu_front.sv @@
module acpu_front
  import acpu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  acpu_in_t  in_data,
  output logic      q_valid,
  output acpu_cmd_t q_cmd,
  input  logic      q_take
);

  acpu_cmd_t slot_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  acpu_fmt_t fmt;
  logic      wr, rd;

  always_comb begin
    fmt = FMT_O;
    case (in_data.command[7:3])
      5'h03, 5'h19, 5'h17, 5'h1F, 5'h15, 5'h0D, 5'h0F, 5'h0B, 5'h09, 5'h1B: fmt = FMT_R;
      default: fmt = FMT_O;
    endcase
    if (fmt == FMT_O) begin
      case (in_data.command[7:1])
        7'h08, 7'h58, 7'h78, 7'h50, 7'h30, 7'h38, 7'h28, 7'h20, 7'h68: fmt = FMT_I;
        default: fmt = FMT_O;
      endcase
    end
    if (in_data.command[4:0] == 5'h04 || in_data.command[4:0] == 5'h14) fmt = FMT_O;
    if (in_data.command[7:2] == 6'h03 || in_data.command[7:2] == 6'h0F ||
        in_data.command[7:2] == 6'h23 || in_data.command[7:2] == 6'h27) fmt = FMT_X;
  end

  assign in_full = (cnt_r == 2'd2);
  assign wr      = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = slot_r[rp_r];
  assign rd      = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wp_r] <= '{fmt: fmt, op: in_data.command, imm: in_data.operand_byte,
                        pin: in_data.port_in};
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

@@ rtl/acpu_back.sv @@
module acpu_back
  import acpu_pkg::*;
#(
  parameter int RAM_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  acpu_cmd_t q_cmd,
  output logic      q_take,
  output logic      out_empty,
  input  logic      out_pop,
  output acpu_out_t out_data
);

  localparam int AW = $clog2(RAM_DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD1, S_RD2, S_EXEC, S_EMIT
  } state_t;

  state_t     state_r;
  logic [7:0] ram [RAM_DEPTH];
  logic [7:0] rdata_r;
  logic [AW-1:0] raddr, addr_r, clr_r;
  logic [11:0] pc_r;
  logic [7:0]  acc_r, sw_r, p1_r, p2_r;
  logic        f1_r;
  acpu_cmd_t   cmd_r;
  logic [7:0]  lo_r;
  logic        ram_rd_r;

  acpu_out_t   items_r [5];
  logic [2:0]  n_r, idx_r;
  logic        ovalid_r;

  logic [7:0]  bank;

  function automatic logic [AW-1:0] ra(input logic [7:0] a);
    logic [8:0] v;
    v = {1'b0, a};
    for (int i = 0; i < 3; i++) begin
      if (v >= 9'(RAM_DEPTH)) v = 9'(v - 9'(RAM_DEPTH));
    end
    return AW'(v);
  endfunction

  assign bank = sw_r[4] ? 8'd24 : 8'd0;

  always_comb begin
    raddr = '0;
    case (state_r)
      S_IDLE:  raddr = (q_cmd.fmt == FMT_I) ? ra(bank + {7'd0, q_cmd.op[0]})
                     : (q_cmd.op == 8'h83) ? ra(8'd8 + {4'd0, 3'(sw_r[2:0] + 3'd7), 1'b0})
                     : ra(bank + {5'd0, q_cmd.op[2:0]});
      S_RD1:   raddr = (cmd_r.fmt == FMT_I) ? ra(rdata_r)
                     : (cmd_r.op == 8'h83) ? addr_r + AW'(1)
                     : addr_r;
      default: raddr = addr_r;
    endcase
  end

  assign out_empty = !ovalid_r;
  assign out_data  = items_r[idx_r];
  assign q_take    = (state_r == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    logic [7:0] op, imm, b, d, res;
    logic [8:0] sum;
    logic [4:0] h;
    logic [11:0] pc;
    logic [7:0] acc, sw, p1, p2;
    logic f1, cy, jmp, cnd, wr, unk;
    logic [1:0] by, cyc;
    logic [2:0] n;
    acpu_out_t it [5];
    logic [3:0] nib;
    logic [9:0] da;
    logic [3:0] ret_hi;
    op = cmd_r.op; imm = cmd_r.imm; d = rdata_r;
    pc = 12'(pc_r + 12'd1); acc = acc_r; sw = sw_r; p1 = p1_r; p2 = p2_r;
    f1 = f1_r; cy = sw_r[7]; jmp = 1'b0; cnd = 1'b0; wr = 1'b0; unk = 1'b0;
    by = 2'd1; cyc = 2'd1; n = 3'd0; res = 8'd0; b = 8'd0; sum = 9'd0; h = 5'd0;
    nib = 4'd0; da = 10'd0; ret_hi = 4'd0;
    for (int i = 0; i < 5; i++) it[i] = '0;
    if (state_r == S_EXEC) begin
      if (op[4:0] == 5'h04 || op[4:0] == 5'h14) begin
        by = 2'd2; cyc = 2'd2;
        pc = 12'(pc + 12'd1);
        if (op[4]) begin
          res = pc[7:0]; ret_hi = pc[11:8]; wr = 1'b1;
          sw = {sw[7:3], 3'(sw[2:0] + 3'd1)};
        end
        pc = {1'b0, op[7:5], imm};
      end else if (cmd_r.fmt == FMT_R || cmd_r.fmt == FMT_I) begin
        case (cmd_r.fmt == FMT_R ? {op[7:3], 3'b000} : {op[7:1], 1'b0})
          8'h18, 8'h10: begin res = 8'(d + 8'd1); wr = 1'b1; end
          8'hC8: begin res = 8'(d - 8'd1); wr = 1'b1; end
          8'hB8, 8'hB0: begin res = imm; wr = 1'b1; by = 2'd2; cyc = 2'd2; end
          8'hF8, 8'hF0: acc = d;
          8'hA8, 8'hA0: begin res = acc_r; wr = 1'b1; end
          8'h68, 8'h60, 8'h78, 8'h70: b = d;
          8'h58, 8'h50: acc = acc_r & d;
          8'h48, 8'h40: acc = acc_r | d;
          default: acc = acc_r ^ d;
        endcase
        if (op[6:5] == 2'b11 && (op[7:4] == 4'h6 || op[7:4] == 4'h7) &&
            (cmd_r.fmt == FMT_R ? op[3] : op[3:1] == 3'b000)) begin
          sum = {1'b0, acc_r} + {1'b0, b} + {8'd0, op[4] & cy};
          h = {1'b0, acc_r[3:0]} + {1'b0, b[3:0]} + {4'd0, op[4] & cy};
          acc = sum[7:0]; sw = {sum[8], h[4], sw[5:0]};
        end
      end else if (cmd_r.fmt == FMT_X) begin
        cyc = 2'd2;
        nib = {op[7] ? {1'b1, op[4]} : {1'b0, op[5]}, op[1:0]};
        it[0] = '{result_kind: KIND_PORT, port_id: PORT_P2,
                  port_value: {p2_r[7:4], nib}, default: '0};
        it[1] = '{result_kind: KIND_STROBE, default: '0};
        if (nib[3:2] == 2'd0) begin
          acc = {4'd0, cmd_r.pin[3:0]};
          p2 = {p2_r[7:4], nib};
          it[2] = '{result_kind: KIND_STROBE, strobe_level: 1'b1, default: '0};
          n = 3'd3;
        end else begin
          p2 = {p2_r[7:4], acc_r[3:0]};
          it[2] = '{result_kind: KIND_PORT, port_id: PORT_P2, port_value: p2, default: '0};
          it[3] = '{result_kind: KIND_STROBE, strobe_level: 1'b1, default: '0};
          n = 3'd4;
        end
      end else begin
        case (op)
          8'h00: ;
          8'h83: begin pc = {rdata_r[3:0], lo_r}; cyc = 2'd2;
                   sw = {sw_r[7:3], 3'(sw_r[2:0] + 3'd7)}; end
          8'hC6: begin jmp = 1'b1; cnd = (acc_r == 8'd0); end
          8'h96: begin jmp = 1'b1; cnd = (acc_r != 8'd0); end
          8'hF6: begin jmp = 1'b1; cnd = cy; end
          8'hE6: begin jmp = 1'b1; cnd = !cy; end
          8'hB6: begin jmp = 1'b1; cnd = sw_r[5]; end
          8'h76: begin jmp = 1'b1; cnd = f1_r; end
          8'h27: acc = 8'd0;
          8'h37: acc = ~acc_r;
          8'h47: acc = {acc_r[3:0], acc_r[7:4]};
          8'h07: acc = 8'(acc_r - 8'd1);
          8'h17: acc = 8'(acc_r + 8'd1);
          8'h23: begin acc = imm; by = 2'd2; cyc = 2'd2; end
          8'hC5: sw = sw_r & ~ST_BS;
          8'hD5: sw = sw_r | ST_BS;
          8'hC7: acc = sw_r | 8'h08;
          8'hD7: sw = acc_r | 8'h08;
          8'h03, 8'h13: begin
            sum = {1'b0, acc_r} + {1'b0, imm} + {8'd0, op[4] & cy};
            h = {1'b0, acc_r[3:0]} + {1'b0, imm[3:0]} + {4'd0, op[4] & cy};
            acc = sum[7:0]; sw = {sum[8], h[4], sw_r[5:0]}; by = 2'd2; cyc = 2'd2;
          end
          8'h57: begin
            da = {2'd0, acc_r};
            if (acc_r[3:0] > 4'd9 || sw_r[6]) da = 10'(da + 10'h06);
            if (da > 10'h9F || sw_r[7]) begin da = 10'(da + 10'h60); sw = sw_r | ST_CY; end
            acc = da[7:0];
          end
          8'h53: begin acc = acc_r & imm; by = 2'd2; cyc = 2'd2; end
          8'h43: begin acc = acc_r | imm; by = 2'd2; cyc = 2'd2; end
          8'hD3: begin acc = acc_r ^ imm; by = 2'd2; cyc = 2'd2; end
          8'hE7: acc = {acc_r[6:0], acc_r[7]};
          8'h77: acc = {acc_r[0], acc_r[7:1]};
          8'hF7: begin sw = {acc_r[7], sw_r[6:0]}; acc = {acc_r[6:0], cy}; end
          8'h67: begin sw = {acc_r[0], sw_r[6:0]}; acc = {cy, acc_r[7:1]}; end
          8'h97: sw = sw_r & ~ST_CY;
          8'hA7: sw = sw_r ^ ST_CY;
          8'h85: sw = sw_r & ~ST_F0;
          8'h95: sw = sw_r ^ ST_F0;
          8'hA5: f1 = 1'b0;
          8'hB5: f1 = !f1_r;
          8'h08, 8'h09, 8'h0A: begin acc = cmd_r.pin; cyc = 2'd2; end
          8'h02, 8'h39, 8'h3A, 8'h98, 8'h88, 8'h99, 8'h9A, 8'h89, 8'h8A: begin
            cyc = 2'd2;
            case (op)
              8'h02:        begin it[0].port_id = PORT_BUS; it[0].port_value = acc_r; end
              8'h39:        begin it[0].port_id = PORT_P1; it[0].port_value = acc_r; end
              8'h3A:        begin it[0].port_id = PORT_P2; it[0].port_value = acc_r; end
              8'h99:        begin it[0].port_id = PORT_P1; it[0].port_value = p1_r & imm; end
              8'h9A:        begin it[0].port_id = PORT_P2; it[0].port_value = p2_r & imm; end
              8'h89:        begin it[0].port_id = PORT_P1; it[0].port_value = p1_r | imm; end
              8'h8A:        begin it[0].port_id = PORT_P2; it[0].port_value = p2_r | imm; end
              default:      begin it[0].port_id = PORT_BUS; it[0].port_value = imm; end
            endcase
            if (op != 8'h02 && op != 8'h39 && op != 8'h3A) by = 2'd2;
            it[0].result_kind = KIND_PORT;
            if (it[0].port_id == PORT_P1) p1 = it[0].port_value;
            if (it[0].port_id == PORT_P2) p2 = it[0].port_value;
            n = 3'd1;
          end
          default: unk = 1'b1;
        endcase
        if (jmp) begin
          by = 2'd2; cyc = 2'd2;
          pc = 12'(pc + 12'd1);
          if (cnd) pc = {pc[11:8], imm};
        end else if (by == 2'd2) begin
          pc = 12'(pc + 12'd1);
        end
      end
      if (cmd_r.fmt != FMT_O && by == 2'd2) pc = 12'(pc + 12'd1);
      it[n] = '{result_kind: KIND_RETIRE, port_id: PORT_BUS, port_value: 8'd0,
                strobe_level: 1'b0, next_pc: pc, acc_out: acc, status_out: sw,
                flag_one: f1, bytes_used: by, cycle_count: cyc, unknown_opcode: unk,
                last: 1'b1};
    end

    if (ram_rd_r) rdata_r <= ram[raddr];
    if (state_r == S_CLEAR) ram[clr_r] <= 8'd0;
    if (state_r == S_EXEC && wr) ram[addr_r] <= res;
    if (state_r == S_EXEC && op[4:0] == 5'h14) ram[AW'(addr_r + AW'(1))] <= {sw_r[7:4], ret_hi};
    if (state_r == S_IDLE && q_valid) begin
      cmd_r <= q_cmd;
      addr_r <= (q_cmd.op[4:0] == 5'h14) ? ra(8'd8 + {4'd0, sw_r[2:0], 1'b0}) : raddr;
    end
    if (state_r == S_RD1) begin
      lo_r <= rdata_r;
      addr_r <= raddr;
    end
    if (state_r == S_EXEC) begin
      for (int i = 0; i < 5; i++) items_r[i] <= it[i];
    end

    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; ram_rd_r <= 1'b0;
      pc_r <= '0; acc_r <= '0; sw_r <= STATUS_RESET; f1_r <= 1'b0;
      p1_r <= 8'hFF; p2_r <= 8'hFF; ovalid_r <= 1'b0; idx_r <= '0; n_r <= '0;
    end else begin
      ram_rd_r <= 1'b1;
      case (state_r)
        S_CLEAR: begin
          clr_r <= AW'(clr_r + AW'(1));
          if (clr_r == AW'(RAM_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (q_valid) state_r <= S_RD1;
        S_RD1: state_r <= S_RD2;
        S_RD2: state_r <= S_EXEC;
        S_EXEC: begin
          pc_r <= pc; acc_r <= acc; sw_r <= sw; f1_r <= f1; p1_r <= p1; p2_r <= p2;
          n_r <= n; idx_r <= '0; ovalid_r <= 1'b1;
          state_r <= S_EMIT;
        end
        S_EMIT: if (out_pop) begin
          if (idx_r == n_r) begin
            ovalid_r <= 1'b0; state_r <= S_IDLE;
          end else begin
            idx_r <= 3'(idx_r + 3'd1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/accumulator_cpu_execute.sv @@
// channel | ports                               | transaction when
// input   | in_push, in_full, in_data           | in_push && !in_full
// result  | out_pop, out_empty, out_data        | out_pop && !out_empty
// The back end takes each instruction through two RAM reads and execute,
// then emits one result item per cycle while out_pop is high; the front
// queue holds two instructions. After reset the register RAM is cleared; no
// instruction is executed until the pass ends. Result stalls hold the back end.
module accumulator_cpu_execute
  import acpu_pkg::*;
#(
  parameter int RAM_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  acpu_in_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output acpu_out_t out_data
);

  logic      q_valid, q_take;
  acpu_cmd_t q_cmd;

  acpu_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data, .q_valid, .q_cmd, .q_take
  );

  acpu_back #(.RAM_DEPTH(RAM_DEPTH)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_take, .out_empty, .out_pop, .out_data
  );

  a_retire_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.last |-> out_data.result_kind == KIND_RETIRE)
    else $error("last on non-retire item");

  a_take_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid)
    else $error("back end took from empty queue");

endmodule

@@ tb/tb_top.sv @@
`default_nettype none

module tb_top;
  import acpu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int N_RANDOM = 480;

  localparam logic [7:0] FMT_MASK = 8'h1F, OP_JMP = 8'h04, OP_CALL = 8'h14;
  localparam logic [7:0] GRP_REG = 8'hF8, GRP_IND = 8'hFE, GRP_EXP = 8'hFC;
  localparam logic [7:0] OPR_INC = 8'h18, OPR_DEC = 8'hC8, OPR_MOVI = 8'hB8, OPR_MOVA = 8'hF8;
  localparam logic [7:0] OPR_MOVR = 8'hA8, OPR_ADD = 8'h68, OPR_ADDC = 8'h78;
  localparam logic [7:0] OPR_ANL = 8'h58, OPR_ORL = 8'h48, OPR_XRL = 8'hD8;
  localparam logic [7:0] OPI_INC = 8'h10, OPI_MOVI = 8'hB0, OPI_MOVA = 8'hF0, OPI_MOVR = 8'hA0;
  localparam logic [7:0] OPI_ADD = 8'h60, OPI_ADDC = 8'h70, OPI_ANL = 8'h50;
  localparam logic [7:0] OPI_ORL = 8'h40, OPI_XRL = 8'hD0;
  localparam logic [7:0] OPX_MOVDA = 8'h0C, OPX_MOVDP = 8'h3C, OPX_ORLD = 8'h8C;
  localparam logic [7:0] OPX_ANLD = 8'h9C;
  localparam logic [7:0] OP_NOP = 8'h00, OP_RET = 8'h83, OP_JZ = 8'hC6, OP_JNZ = 8'h96;
  localparam logic [7:0] OP_JC = 8'hF6, OP_JNC = 8'hE6, OP_JF0 = 8'hB6, OP_JF1 = 8'h76;
  localparam logic [7:0] OP_CLRA = 8'h27, OP_CPLA = 8'h37, OP_SWAP = 8'h47, OP_DECA = 8'h07;
  localparam logic [7:0] OP_INCA = 8'h17, OP_MOVAI = 8'h23, OP_SEL0 = 8'hC5, OP_SEL1 = 8'hD5;
  localparam logic [7:0] OP_MOVAPSW = 8'hC7, OP_MOVPSWA = 8'hD7, OP_ADDI = 8'h03;
  localparam logic [7:0] OP_ADDCI = 8'h13, OP_DA = 8'h57, OP_ANLI = 8'h53, OP_ORLI = 8'h43;
  localparam logic [7:0] OP_XRLI = 8'hD3, OP_RL = 8'hE7, OP_RR = 8'h77, OP_RLC = 8'hF7;
  localparam logic [7:0] OP_RRC = 8'h67, OP_CLRC = 8'h97, OP_CPLC = 8'hA7, OP_CLRF0 = 8'h85;
  localparam logic [7:0] OP_CPLF0 = 8'h95, OP_CLRF1 = 8'hA5, OP_CPLF1 = 8'hB5;
  localparam logic [7:0] OP_INS = 8'h08, OP_INP1 = 8'h09, OP_INP2 = 8'h0A, OP_OUTL = 8'h02;
  localparam logic [7:0] OP_OUTP1 = 8'h39, OP_OUTP2 = 8'h3A, OP_ORLBUS = 8'h88;
  localparam logic [7:0] OP_ANLBUS = 8'h98, OP_ANLP1 = 8'h99, OP_ANLP2 = 8'h9A;
  localparam logic [7:0] OP_ORLP1 = 8'h89, OP_ORLP2 = 8'h8A, OP_UNUSED = 8'h01;

  logic clk, rst_n, in_push, in_full, out_empty, out_pop;
  acpu_in_t in_data;
  acpu_out_t out_data;

  accumulator_cpu_execute #(.RAM_DEPTH(DEPTH)) dut (.*);

  logic [11:0] cpu_pc;
  logic [7:0] cpu_acc, cpu_psw, cpu_p1, cpu_p2;
  logic cpu_f1;
  logic [7:0] cpu_ram [DEPTH];
  acpu_out_t pending_results [$];
  int err_cnt, retired_cnt, side_cnt;
  int send_idle_pct, pop_stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("tb_top: errors");
    $finish;
  end

  function automatic acpu_out_t side_item(logic [1:0] kind, logic [1:0] port,
                                          logic [7:0] val, logic level);
    acpu_out_t r;
    r = '0;
    r.result_kind = kind;
    r.port_id = port;
    r.port_value = val;
    r.strobe_level = level;
    return r;
  endfunction

  function automatic int reg_slot(logic [2:0] n);
    return ((cpu_psw & ST_BS) ? 24 : 0) + n;
  endfunction

  task automatic drive_port(logic [1:0] port, logic [7:0] v);
    if (port == PORT_P1) cpu_p1 = v;
    if (port == PORT_P2) cpu_p2 = v;
    pending_results.push_back(side_item(KIND_PORT, port, v, 1'b0));
  endtask

  task automatic acc_add(logic [7:0] b, logic cin);
    logic [8:0] sum;
    logic [4:0] half;
    sum = cpu_acc + b + cin;
    half = cpu_acc[3:0] + b[3:0] + cin;
    cpu_acc = sum[7:0];
    cpu_psw = cpu_psw & ~(ST_CY | ST_AC);
    if (sum[8]) cpu_psw = cpu_psw | ST_CY;
    if (half[4]) cpu_psw = cpu_psw | ST_AC;
  endtask

  task automatic expander_access(logic [1:0] cmd, logic [1:0] port, logic [7:0] pin);
    drive_port(PORT_P2, {cpu_p2[7:4], cmd, port});
    pending_results.push_back(side_item(KIND_STROBE, PORT_BUS, 8'h00, 1'b0));
    if (cmd == 2'd0) cpu_acc = {4'h0, pin[3:0]};
    else drive_port(PORT_P2, {cpu_p2[7:4], cpu_acc[3:0]});
    pending_results.push_back(side_item(KIND_STROBE, PORT_BUS, 8'h00, 1'b1));
  endtask

  task automatic execute_instr(acpu_in_t it);
    logic [7:0] op, imm;
    logic [11:0] npc;
    logic [1:0] nbytes, ncyc;
    logic unk, cy, handled, jmp, cond;
    logic [2:0] sp;
    int rg, ia, base;
    acpu_out_t r;
    op = it.command;
    imm = it.operand_byte;
    npc = cpu_pc + 12'd1;
    nbytes = 2'd1;
    ncyc = 2'd1;
    unk = 1'b0;
    cy = cpu_psw[7];
    handled = 1'b1;
    jmp = 1'b0;
    cond = 1'b0;
    if ((op & FMT_MASK) == OP_JMP || (op & FMT_MASK) == OP_CALL) begin
      nbytes = 2'd2;
      ncyc = 2'd2;
      npc = npc + 12'd1;
      if ((op & FMT_MASK) == OP_CALL) begin
        sp = cpu_psw[2:0];
        base = 8 + 2 * sp;
        cpu_ram[base % DEPTH] = npc[7:0];
        cpu_ram[(base + 1) % DEPTH] = {cpu_psw[7:4], npc[11:8]};
        cpu_psw[2:0] = sp + 3'd1;
      end
      npc = {1'b0, op[7:5], imm};
    end else begin
      rg = reg_slot(op[2:0]);
      case (op & GRP_REG)
        OPR_INC: cpu_ram[rg] = cpu_ram[rg] + 8'd1;
        OPR_DEC: cpu_ram[rg] = cpu_ram[rg] - 8'd1;
        OPR_MOVI: begin
          cpu_ram[rg] = imm;
          nbytes = 2'd2;
          ncyc = 2'd2;
        end
        OPR_MOVA: cpu_acc = cpu_ram[rg];
        OPR_MOVR: cpu_ram[rg] = cpu_acc;
        OPR_ADD: acc_add(cpu_ram[rg], 1'b0);
        OPR_ADDC: acc_add(cpu_ram[rg], cy);
        OPR_ANL: cpu_acc = cpu_acc & cpu_ram[rg];
        OPR_ORL: cpu_acc = cpu_acc | cpu_ram[rg];
        OPR_XRL: cpu_acc = cpu_acc ^ cpu_ram[rg];
        default: handled = 1'b0;
      endcase
      if (!handled) begin
        ia = cpu_ram[reg_slot({2'b00, op[0]})] % DEPTH;
        handled = 1'b1;
        case (op & GRP_IND)
          OPI_INC: cpu_ram[ia] = cpu_ram[ia] + 8'd1;
          OPI_MOVI: begin
            cpu_ram[ia] = imm;
            nbytes = 2'd2;
            ncyc = 2'd2;
          end
          OPI_MOVA: cpu_acc = cpu_ram[ia];
          OPI_MOVR: cpu_ram[ia] = cpu_acc;
          OPI_ADD: acc_add(cpu_ram[ia], 1'b0);
          OPI_ADDC: acc_add(cpu_ram[ia], cy);
          OPI_ANL: cpu_acc = cpu_acc & cpu_ram[ia];
          OPI_ORL: cpu_acc = cpu_acc | cpu_ram[ia];
          OPI_XRL: cpu_acc = cpu_acc ^ cpu_ram[ia];
          default: handled = 1'b0;
        endcase
      end
      if (!handled) begin
        handled = 1'b1;
        ncyc = 2'd2;
        case (op & GRP_EXP)
          OPX_MOVDA: expander_access(2'd0, op[1:0], it.port_in);
          OPX_MOVDP: expander_access(2'd1, op[1:0], it.port_in);
          OPX_ORLD: expander_access(2'd2, op[1:0], it.port_in);
          OPX_ANLD: expander_access(2'd3, op[1:0], it.port_in);
          default: begin
            handled = 1'b0;
            ncyc = 2'd1;
          end
        endcase
      end
      if (!handled) begin
        case (op)
          OP_NOP: ;
          OP_RET: begin
            sp = cpu_psw[2:0] - 3'd1;
            base = 8 + 2 * sp;
            npc = {cpu_ram[(base + 1) % DEPTH][3:0], cpu_ram[base % DEPTH]};
            cpu_psw[2:0] = sp;
            ncyc = 2'd2;
          end
          OP_JZ: begin jmp = 1'b1; cond = (cpu_acc == 8'd0); end
          OP_JNZ: begin jmp = 1'b1; cond = (cpu_acc != 8'd0); end
          OP_JC: begin jmp = 1'b1; cond = cy; end
          OP_JNC: begin jmp = 1'b1; cond = !cy; end
          OP_JF0: begin jmp = 1'b1; cond = ((cpu_psw & ST_F0) != 8'd0); end
          OP_JF1: begin jmp = 1'b1; cond = cpu_f1; end
          OP_CLRA: cpu_acc = 8'd0;
          OP_CPLA: cpu_acc = ~cpu_acc;
          OP_SWAP: cpu_acc = {cpu_acc[3:0], cpu_acc[7:4]};
          OP_DECA: cpu_acc = cpu_acc - 8'd1;
          OP_INCA: cpu_acc = cpu_acc + 8'd1;
          OP_MOVAI: begin cpu_acc = imm; nbytes = 2'd2; ncyc = 2'd2; end
          OP_SEL0: cpu_psw = cpu_psw & ~ST_BS;
          OP_SEL1: cpu_psw = cpu_psw | ST_BS;
          OP_MOVAPSW: cpu_acc = cpu_psw | STATUS_RESET;
          OP_MOVPSWA: cpu_psw = cpu_acc | STATUS_RESET;
          OP_ADDI: begin acc_add(imm, 1'b0); nbytes = 2'd2; ncyc = 2'd2; end
          OP_ADDCI: begin acc_add(imm, cy); nbytes = 2'd2; ncyc = 2'd2; end
          OP_DA: begin
            logic [8:0] a;
            a = {1'b0, cpu_acc};
            if (a[3:0] > 4'd9 || (cpu_psw & ST_AC)) a = a + 9'h06;
            if (a > 9'h9F || (cpu_psw & ST_CY)) begin
              a = a + 9'h60;
              cpu_psw = cpu_psw | ST_CY;
            end
            cpu_acc = a[7:0];
          end
          OP_ANLI: begin cpu_acc = cpu_acc & imm; nbytes = 2'd2; ncyc = 2'd2; end
          OP_ORLI: begin cpu_acc = cpu_acc | imm; nbytes = 2'd2; ncyc = 2'd2; end
          OP_XRLI: begin cpu_acc = cpu_acc ^ imm; nbytes = 2'd2; ncyc = 2'd2; end
          OP_RL: cpu_acc = {cpu_acc[6:0], cpu_acc[7]};
          OP_RR: cpu_acc = {cpu_acc[0], cpu_acc[7:1]};
          OP_RLC: begin
            cpu_psw = (cpu_psw & ~ST_CY) | (cpu_acc & 8'h80);
            cpu_acc = {cpu_acc[6:0], cy};
          end
          OP_RRC: begin
            cpu_psw = (cpu_psw & ~ST_CY) | {cpu_acc[0], 7'd0};
            cpu_acc = {cy, cpu_acc[7:1]};
          end
          OP_CLRC: cpu_psw = cpu_psw & ~ST_CY;
          OP_CPLC: cpu_psw = cpu_psw ^ ST_CY;
          OP_CLRF0: cpu_psw = cpu_psw & ~ST_F0;
          OP_CPLF0: cpu_psw = cpu_psw ^ ST_F0;
          OP_CLRF1: cpu_f1 = 1'b0;
          OP_CPLF1: cpu_f1 = ~cpu_f1;
          OP_INS, OP_INP1, OP_INP2: begin cpu_acc = it.port_in; ncyc = 2'd2; end
          OP_OUTL: begin drive_port(PORT_BUS, cpu_acc); ncyc = 2'd2; end
          OP_OUTP1: begin drive_port(PORT_P1, cpu_acc); ncyc = 2'd2; end
          OP_OUTP2: begin drive_port(PORT_P2, cpu_acc); ncyc = 2'd2; end
          OP_ANLBUS, OP_ORLBUS: begin
            drive_port(PORT_BUS, imm); nbytes = 2'd2; ncyc = 2'd2;
          end
          OP_ANLP1: begin drive_port(PORT_P1, cpu_p1 & imm); nbytes = 2'd2; ncyc = 2'd2; end
          OP_ANLP2: begin drive_port(PORT_P2, cpu_p2 & imm); nbytes = 2'd2; ncyc = 2'd2; end
          OP_ORLP1: begin drive_port(PORT_P1, cpu_p1 | imm); nbytes = 2'd2; ncyc = 2'd2; end
          OP_ORLP2: begin drive_port(PORT_P2, cpu_p2 | imm); nbytes = 2'd2; ncyc = 2'd2; end
          default: unk = 1'b1;
        endcase
      end
      if (nbytes == 2'd2 && !jmp) npc = npc + 12'd1;
      if (jmp) begin
        nbytes = 2'd2;
        ncyc = 2'd2;
        npc = npc + 12'd1;
        if (cond) npc = {npc[11:8], imm};
      end
    end
    cpu_pc = npc;
    r = '0;
    r.result_kind = KIND_RETIRE;
    r.next_pc = cpu_pc;
    r.acc_out = cpu_acc;
    r.status_out = cpu_psw;
    r.flag_one = cpu_f1;
    r.bytes_used = nbytes;
    r.cycle_count = ncyc;
    r.unknown_opcode = unk;
    r.last = 1'b1;
    pending_results.push_back(r);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    acpu_out_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: %p", out_data);
        err_cnt++;
      end else begin
        e = pending_results.pop_front();
        check_field("result_kind", e.result_kind, out_data.result_kind);
        check_field("port_id", e.port_id, out_data.port_id);
        check_field("port_value", e.port_value, out_data.port_value);
        check_field("strobe_level", e.strobe_level, out_data.strobe_level);
        check_field("next_pc", e.next_pc, out_data.next_pc);
        check_field("acc_out", e.acc_out, out_data.acc_out);
        check_field("status_out", e.status_out, out_data.status_out);
        check_field("flag_one", e.flag_one, out_data.flag_one);
        check_field("bytes_used", e.bytes_used, out_data.bytes_used);
        check_field("cycle_count", e.cycle_count, out_data.cycle_count);
        check_field("unknown_opcode", e.unknown_opcode, out_data.unknown_opcode);
        check_field("last", e.last, out_data.last);
        if (e.result_kind == KIND_RETIRE) retired_cnt++;
        else side_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  task automatic send_instr(acpu_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    execute_instr(it);
  endtask

  typedef struct {
    acpu_in_t stim;
    logic known;
    acpu_out_t retire;
  } stim_row_t;

  function automatic stim_row_t row(logic [7:0] op, logic [7:0] imm, logic [7:0] pin);
    stim_row_t s;
    s.stim = '{op, imm, pin};
    s.known = 1'b0;
    s.retire = '0;
    return s;
  endfunction

  function automatic stim_row_t row_known(logic [7:0] op, logic [7:0] imm,
                                          logic [11:0] pc, logic [7:0] acc,
                                          logic [7:0] psw, logic [1:0] nb, logic unk);
    stim_row_t s;
    s = row(op, imm, 8'h00);
    s.known = 1'b1;
    s.retire = '{KIND_RETIRE, PORT_BUS, 8'h00, 1'b0, pc, acc, psw, 1'b0, nb, nb, unk, 1'b1};
    return s;
  endfunction

  function automatic acpu_in_t random_instr();
    logic [7:0] pool [] = '{OPR_MOVI, OPR_INC, OPR_ADD, OPR_ADDC, OPR_MOVR, OPR_DEC,
      OPI_MOVI, OPI_MOVA, OPI_ADDC, OPI_INC, OPX_MOVDA, OPX_MOVDP, OPX_ORLD, OPX_ANLD,
      OP_JMP, OP_CALL, OP_CALL, OP_RET, OP_RET, OP_JZ, OP_JNZ, OP_JC, OP_JNC, OP_JF0,
      OP_JF1, OP_DA, OP_ADDI, OP_ADDCI, OP_MOVAI, OP_SEL0, OP_SEL1, OP_MOVPSWA,
      OP_MOVAPSW, OP_RLC, OP_RRC, OP_CPLC, OP_CPLF0, OP_CPLF1, OP_INS, OP_OUTP1,
      OP_OUTP2, OP_ANLP2, OP_ORLP1, OP_ANLBUS, OP_SWAP};
    acpu_in_t it;
    logic [7:0] op;
    it = '{8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255))};
    if ($urandom_range(99) < 75) begin
      op = pool[$urandom_range(pool.size() - 1)];
      if (op[7:3] != 5'b00000 && op[2:0] == 3'b000) op[2:0] = 3'($urandom_range(7));
      else if (op == OPI_MOVI || op == OPI_MOVA || op == OPI_ADDC || op == OPI_INC)
        op[0] = 1'($urandom_range(1));
      else if ((op & GRP_EXP) == op && op[3:2] == 2'b11) op[1:0] = 2'($urandom_range(3));
      if ((op & FMT_MASK) == OP_JMP || (op & FMT_MASK) == OP_CALL)
        op[7:5] = 3'($urandom_range(7));
      it.command = op;
    end
    return it;
  endfunction

  initial begin
    stim_row_t plan [$];
    int phase_idle [4] = '{0, 68, 0, 21};
    int phase_stall [4] = '{0, 0, 68, 21};
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_data <= '0;
    out_pop <= 1'b0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    err_cnt = 0;
    retired_cnt = 0;
    side_cnt = 0;
    cpu_pc = '0;
    cpu_acc = '0;
    cpu_psw = STATUS_RESET;
    cpu_f1 = 1'b0;
    cpu_p1 = 8'hFF;
    cpu_p2 = 8'hFF;
    foreach (cpu_ram[i]) cpu_ram[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    plan.push_back(row_known(OP_NOP, 8'h00, 12'h001, 8'h00, 8'h08, 2'd1, 1'b0));
    plan.push_back(row_known(OP_MOVAI, 8'hFF, 12'h003, 8'hFF, 8'h08, 2'd2, 1'b0));
    plan.push_back(row_known(OP_ADDI, 8'h01, 12'h005, 8'h00, 8'hC8, 2'd2, 1'b0));
    plan.push_back(row_known(OP_UNUSED, 8'hFF, 12'h006, 8'h00, 8'hC8, 2'd1, 1'b1));
    plan.push_back(row(OP_ADDCI, 8'h99, 8'h00));
    plan.push_back(row(OP_DA, 8'h00, 8'h00));
    plan.push_back(row(OPR_MOVI | 8'h01, 8'h30, 8'h00));
    plan.push_back(row(OPI_MOVI | 8'h01, 8'hA5, 8'h00));
    plan.push_back(row(OPI_ADDC | 8'h01, 8'h00, 8'h00));
    plan.push_back(row(OP_SEL1, 8'h00, 8'h00));
    plan.push_back(row(OPR_DEC | 8'h07, 8'h00, 8'h00));
    plan.push_back(row(OP_CALL | 8'hE0, 8'hFF, 8'h00));
    plan.push_back(row(OP_RET, 8'h00, 8'h00));
    plan.push_back(row(OP_JNZ, 8'h00, 8'h00));
    plan.push_back(row(OP_JC, 8'h80, 8'h00));
    plan.push_back(row(OPX_MOVDA | 8'h03, 8'h00, 8'hFF));
    plan.push_back(row(OPX_ANLD | 8'h02, 8'h00, 8'h00));
    plan.push_back(row(OP_ANLP2, 8'h0F, 8'h00));
    plan.push_back(row(OP_ORLBUS, 8'h5A, 8'h00));
    plan.push_back(row(OP_INP1, 8'h00, 8'h80));
    plan.push_back(row(OP_OUTP1, 8'h00, 8'h00));
    plan.push_back(row(OP_RRC, 8'h00, 8'h00));
    plan.push_back(row(OP_CPLF1, 8'h00, 8'h00));
    plan.push_back(row(OP_JF1, 8'h42, 8'h00));
    plan.push_back(row(OP_MOVPSWA, 8'h00, 8'h00));

    foreach (plan[i]) begin
      send_instr(plan[i].stim);
      if (plan[i].known) pending_results[$] = plan[i].retire;
    end
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_idle[p];
      pop_stall_pct = phase_stall[p];
      for (int k = 0; k < N_RANDOM / 4; k++) send_instr(random_instr());
    end
    in_push <= 1'b0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d instructions retired, %0d port and strobe transactions",
             retired_cnt, side_cnt);
    if (err_cnt == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

`default_nettype wire
